@@ src/rotate_source_address_gen_defines.svh @@
// assertion macros shared by the rotate source address generator
`ifndef ROTATE_SOURCE_ADDRESS_GEN_DEFINES_SVH
`define ROTATE_SOURCE_ADDRESS_GEN_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked check, skipped while reset is active
`define RSAG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// clocked check that also holds through reset
`define RSAG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSAG_ASSERT(label, clk, rst_n, prop, msg)
`define RSAG_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ src/rsag_pkg.sv @@
// types and constants for the rotate source address generator
`timescale 1ns / 1ps

package rsag_pkg;

    localparam int MAX_DIM_DEF = 1024;

    localparam int DIM_W   = 11;
    localparam int COEF_W  = 16;
    localparam int COORD_W = 10;
    localparam int INDEX_W = 20;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam int FRAC_BITS = 14;

    localparam logic [DIM_W-1:0]  RST_WIDTH  = 11'd64;
    localparam logic [DIM_W-1:0]  RST_HEIGHT = 11'd64;
    localparam logic [COEF_W-1:0] RST_SINE   = 16'sd0;
    localparam logic [COEF_W-1:0] RST_COSINE = 16'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_SINE   = 2'd2,
        CFG_COSINE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
    } t_in;

    typedef struct packed {
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic [INDEX_W-1:0] src_index;
        logic               outside;
    } t_out;

endpackage

@@ src/rotate_source_address_gen.sv @@
// top level of the rotate source address generator
`timescale 1ns / 1ps
`include "rotate_source_address_gen_defines.svh"

// Maps each destination pixel (dest_x, dest_y) to the source pixel that
// nearest-neighbor rotation about the picture center lands on, with its
// linear address src_x + image_width*src_y, or flags it as outside. One
// transaction per clock is accepted while the output is not stalled; each
// passes through the seven-stage pipeline: offsets, coefficient multiplies,
// dot-product sums, rounding, center add-back, bounds check with row
// multiply, address add. A stall at the output freezes the whole pipeline.
// Config registers are written via i_cfg_we / i_cfg_index / i_cfg_data; the
// user must do so only while no transaction is in flight; the block won't check.
module rotate_source_address_gen #(
    parameter int MAX_DIM = rsag_pkg::MAX_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rsag_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rsag_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  rsag_pkg::t_in                    i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output rsag_pkg::t_out                   o_out_data
);

    localparam int NSTG  = 7;
    localparam int OFS_W = 12;
    localparam int PRD_W = OFS_W + rsag_pkg::COEF_W;
    localparam int SUM_W = PRD_W + 2;
    localparam int MAG_W = SUM_W - rsag_pkg::FRAC_BITS;
    localparam int SRC_W = MAG_W + 2;
    localparam int HLF_W = rsag_pkg::DIM_W - 1;
    localparam int ROW_W = 2 * rsag_pkg::DIM_W;
    localparam logic [SUM_W-1:0] HALF_LSB = SUM_W'(1) << (rsag_pkg::FRAC_BITS - 1);

    // configuration
    logic [rsag_pkg::DIM_W-1:0]         r_width;
    logic [rsag_pkg::DIM_W-1:0]         r_height;
    logic signed [rsag_pkg::COEF_W-1:0] r_sine;
    logic signed [rsag_pkg::COEF_W-1:0] r_cosine;

    logic [rsag_pkg::DIM_W-1:0] w_c;
    logic [rsag_pkg::DIM_W-1:0] h_c;
    logic [HLF_W-1:0]           hw;
    logic [HLF_W-1:0]           hh;

    // pipeline
    logic [NSTG-1:0]            r_vld;
    logic [NSTG-1:0]            n_vld;
    logic                       en;

    logic signed [OFS_W-1:0]    r_dx1, r_dy1;
    logic signed [OFS_W-1:0]    n_dx1, n_dy1;
    logic signed [PRD_W-1:0]    r_xc2, r_ys2, r_yc2, r_xs2;
    logic signed [SUM_W-1:0]    r_px3, r_py3;
    logic signed [SUM_W-1:0]    n_px3, n_py3;
    logic [MAG_W-1:0]           r_mx4, r_my4;
    logic                       r_nx4, r_ny4;
    logic [SUM_W-1:0]           n_magx, n_magy;
    logic signed [SRC_W-1:0]    r_sx5, r_sy5;
    logic signed [SRC_W-1:0]    n_sx5, n_sy5;
    logic [rsag_pkg::DIM_W-1:0] r_sx6, r_sy6;
    logic                       r_in6;
    logic [ROW_W-1:0]           r_row6;
    logic                       n_in6;
    rsag_pkg::t_out             r_out;
    rsag_pkg::t_out             n_out;
    logic [ROW_W-1:0]           n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rsag_pkg::RST_WIDTH;
            r_height <= rsag_pkg::RST_HEIGHT;
            r_sine   <= rsag_pkg::RST_SINE;
            r_cosine <= rsag_pkg::RST_COSINE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rsag_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[rsag_pkg::DIM_W-1:0];
                rsag_pkg::CFG_HEIGHT: r_height <= i_cfg_data[rsag_pkg::DIM_W-1:0];
                rsag_pkg::CFG_SINE:   r_sine   <= i_cfg_data;
                rsag_pkg::CFG_COSINE: r_cosine <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // dimensions clamped to the largest supported picture
    always_comb begin
        w_c = (32'(r_width) > MAX_DIM) ? rsag_pkg::DIM_W'(MAX_DIM) : r_width;
        h_c = (32'(r_height) > MAX_DIM) ? rsag_pkg::DIM_W'(MAX_DIM) : r_height;
        hw  = w_c[rsag_pkg::DIM_W-1:1];
        hh  = h_c[rsag_pkg::DIM_W-1:1];
    end

    assign o_in_stall = r_vld[NSTG-1] && i_out_stall;
    assign en         = !o_in_stall;
    assign n_vld      = {r_vld[NSTG-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= n_vld;
        end
    end

    always_comb begin
        // offsets from center
        n_dx1 = $signed(OFS_W'(i_in_data.dest_x)) - $signed(OFS_W'(hw));
        n_dy1 = $signed(OFS_W'(i_in_data.dest_y)) - $signed(OFS_W'(hh));

        // dot products
        n_px3 = SUM_W'(r_xc2) + SUM_W'(r_ys2);
        n_py3 = SUM_W'(r_yc2) - SUM_W'(r_xs2);

        // magnitude plus half lsb, round half away from zero
        n_magx = r_px3[SUM_W-1] ? (~r_px3 + HALF_LSB + SUM_W'(1)) : (r_px3 + HALF_LSB);
        n_magy = r_py3[SUM_W-1] ? (~r_py3 + HALF_LSB + SUM_W'(1)) : (r_py3 + HALF_LSB);

        // center add-back
        n_sx5 = r_nx4 ? ($signed(SRC_W'(hw)) - $signed(SRC_W'(r_mx4)))
                      : ($signed(SRC_W'(hw)) + $signed(SRC_W'(r_mx4)));
        n_sy5 = r_ny4 ? ($signed(SRC_W'(hh)) - $signed(SRC_W'(r_my4)))
                      : ($signed(SRC_W'(hh)) + $signed(SRC_W'(r_my4)));

        // bounds check
        n_in6 = !r_sx5[SRC_W-1] && !r_sy5[SRC_W-1]
             && (r_sx5 < $signed(SRC_W'(w_c))) && (r_sy5 < $signed(SRC_W'(h_c)));

        // linear address and output select
        n_idx = ROW_W'(r_sx6) + r_row6;
        if (r_in6) begin
            n_out.src_x     = r_sx6[rsag_pkg::COORD_W-1:0];
            n_out.src_y     = r_sy6[rsag_pkg::COORD_W-1:0];
            n_out.src_index = n_idx[rsag_pkg::INDEX_W-1:0];
            n_out.outside   = 1'b0;
        end else begin
            n_out.src_x     = '0;
            n_out.src_y     = '0;
            n_out.src_index = '0;
            n_out.outside   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx1  <= n_dx1;
            r_dy1  <= n_dy1;
            r_xc2  <= r_dx1 * r_cosine;
            r_ys2  <= r_dy1 * r_sine;
            r_yc2  <= r_dy1 * r_cosine;
            r_xs2  <= r_dx1 * r_sine;
            r_px3  <= n_px3;
            r_py3  <= n_py3;
            r_mx4  <= n_magx[SUM_W-1:rsag_pkg::FRAC_BITS];
            r_my4  <= n_magy[SUM_W-1:rsag_pkg::FRAC_BITS];
            r_nx4  <= r_px3[SUM_W-1];
            r_ny4  <= r_py3[SUM_W-1];
            r_sx5  <= n_sx5;
            r_sy5  <= n_sy5;
            r_sx6  <= r_sx5[rsag_pkg::DIM_W-1:0];
            r_sy6  <= r_sy5[rsag_pkg::DIM_W-1:0];
            r_in6  <= n_in6;
            r_row6 <= w_c * r_sy5[rsag_pkg::DIM_W-1:0];
            r_out  <= n_out;
        end
    end

    assign o_out_valid = r_vld[NSTG-1];
    assign o_out_data  = r_out;

    `RSAG_ASSERT(a_outside_zero, i_clk, i_rst_n,
        (o_out_valid && o_out_data.outside) |-> (o_out_data.src_x == '0
            && o_out_data.src_y == '0 && o_out_data.src_index == '0),
        "outside result carries nonzero address")
    `RSAG_ASSERT(a_inside_bounds, i_clk, i_rst_n,
        (o_out_valid && !o_out_data.outside) |->
            (rsag_pkg::DIM_W'(o_out_data.src_x) < w_c
            && rsag_pkg::DIM_W'(o_out_data.src_y) < h_c),
        "inside result beyond picture")
    `RSAG_ASSERT(a_accept_enters, i_clk, i_rst_n,
        (i_in_valid && !o_in_stall) |=> r_vld[0],
        "accepted transaction missing from first stage")
    `RSAG_ASSERT(a_stall_freezes, i_clk, i_rst_n,
        o_in_stall |=> $stable(r_vld),
        "pipeline moved during output stall")

endmodule
